// ===== hdl/soa_pkg.sv =====
// Shared types, codes and defaults for the slab object allocator.
package soa_pkg;

  localparam int SLAB_SLOTS_DEF  = 16;
  localparam int MAX_OBJECTS_DEF = 256;

  localparam int REQ_W    = 2;
  localparam int SLAB_W   = 4;
  localparam int OBJ_W    = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int BUDGET_W   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BUDGET = 1'b1;

  localparam logic [CFG_DATA_W-1:0] OPS_RST    = 9'd256;
  localparam logic [BUDGET_W-1:0]   BUDGET_RST = 5'd16;
  localparam logic [COUNT_W-1:0]    COUNT_SAT  = 5'd31;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_SHRINK = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_SLAB     = 3'd1,
    ST_NOT_OWNED   = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_BAD_INDEX   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    TAG_NONE    = 2'd0,
    TAG_FULL    = 2'd1,
    TAG_PARTIAL = 2'd2,
    TAG_EMPTY   = 2'd3
  } tag_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_META,
    S_LINK,
    S_PLAN,
    S_FX_RD,
    S_FX_WR,
    S_WB,
    S_SHR_CHK,
    S_SHR_RD,
    S_DONE
  } state_t;

endpackage

// ===== hdl/soa_channels.sv =====
// Request and result channel interfaces of the slab object allocator.
interface soa_in_if;
  logic                        valid;
  logic                        ready;
  logic [soa_pkg::REQ_W-1:0]   req_type;
  logic [soa_pkg::SLAB_W-1:0]  slab_sel;
  logic [soa_pkg::OBJ_W-1:0]   object_sel;

  modport source (output valid, req_type, slab_sel, object_sel, input ready);
  modport sink   (input valid, req_type, slab_sel, object_sel, output ready);
endinterface

interface soa_out_if;
  logic                         valid;
  logic                         ready;
  logic [soa_pkg::STATUS_W-1:0] status;
  logic [soa_pkg::SLAB_W-1:0]   granted_slab;
  logic [soa_pkg::OBJ_W-1:0]    granted_object;
  logic [soa_pkg::COUNT_W-1:0]  released_count;

  modport source (output valid, status, granted_slab, granted_object, released_count,
                  input ready);
  modport sink   (input valid, status, granted_slab, granted_object, released_count,
                  output ready);
endinterface

// ===== hdl/soa_link_ram.sv =====
// Free-list link memory: one write and one registered read port.
module soa_link_ram #(
  parameter int DEPTH = soa_pkg::SLAB_SLOTS_DEF * soa_pkg::MAX_OBJECTS_DEF,
  parameter int AW    = $clog2(soa_pkg::SLAB_SLOTS_DEF * soa_pkg::MAX_OBJECTS_DEF),
  parameter int DW    = $clog2(soa_pkg::MAX_OBJECTS_DEF + 1)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/soa_meta_store.sv =====
// Per-slab record memory with per-entry valid bits; unwritten entries read as reset.
module soa_meta_store #(
  parameter int            DEPTH   = soa_pkg::SLAB_SLOTS_DEF,
  parameter int            AW      = $clog2(soa_pkg::SLAB_SLOTS_DEF),
  parameter int            DW      = 8,
  parameter logic [DW-1:0] RST_VAL = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0]    mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] valid_nxt;
  logic [DW-1:0]    q_r;
  logic             hit_r;

  always_comb begin
    valid_nxt = valid_r;
    if (we) begin
      valid_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= valid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    q_r <= mem_r[raddr];
  end

  assign rdata = hit_r ? q_r : RST_VAL;

endmodule

// ===== hdl/slab_object_allocator_core.sv =====
// Slab object allocator top level: request sequencer over slab record and link memories.
//
//  channel   | role   | transaction
//  ----------+--------+---------------------------------------------------------
//  in_ch     | sink   | req_type, slab_sel, object_sel
//  out_ch    | source | status, granted_slab, granted_object, released_count
//  cfg_*     | write  | cfg_index picks the object count or the slab budget register
//
//  One request at a time. Alloc and free read the slab record first; an alloc that takes an
//  object off the free list then reads the link memory, and when the slab changes list each
//  neighbor record that needs a new link is read and rewritten before the slab's own record
//  is written back. Shrink releases each slab on the empty list in turn and fixes the link of
//  its neighbor. Apart from the link read, the steps follow from the single read and write
//  port of the slab record memory. Reset is synchronous; no clearing pass. A stalled result
//  holds in the output register while the next request is accepted.
module slab_object_allocator_core #(
  parameter int SLAB_SLOTS  = soa_pkg::SLAB_SLOTS_DEF,
  parameter int MAX_OBJECTS = soa_pkg::MAX_OBJECTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [soa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [soa_pkg::CFG_DATA_W-1:0]   cfg_data,
  soa_in_if.sink                           in_ch,
  soa_out_if.source                        out_ch
);

  localparam int SW  = $clog2(SLAB_SLOTS + 1);
  localparam int SIW = (SLAB_SLOTS > 1) ? $clog2(SLAB_SLOTS) : 1;
  localparam int OW  = $clog2(MAX_OBJECTS + 1);
  localparam int LAW = $clog2(SLAB_SLOTS * MAX_OBJECTS);
  localparam logic [SW-1:0] SLAB_NIL = SW'(SLAB_SLOTS);
  localparam logic [OW-1:0] OBJ_NIL  = OW'(MAX_OBJECTS);

  typedef struct packed {
    soa_pkg::tag_t tag;
    logic [SW-1:0] link_next;
    logic [SW-1:0] link_prev;
    logic [OW-1:0] used;
    logic [OW-1:0] fresh;
    logic [OW-1:0] fhead;
  } meta_t;

  typedef struct packed {
    logic          en;
    logic          is_next;
    logic [SW-1:0] addr;
    logic [SW-1:0] val;
  } fix_t;

  localparam int MW = $bits(meta_t);
  localparam meta_t META_RST = '{tag: soa_pkg::TAG_NONE, link_next: SLAB_NIL,
                                 link_prev: SLAB_NIL, used: '0, fresh: '0, fhead: OBJ_NIL};

  soa_pkg::state_t  state_r, state_nxt;
  soa_pkg::req_t    req_r, req_nxt;
  soa_pkg::status_t stat_r, stat_nxt;
  soa_pkg::tag_t    orig_r, orig_nxt;
  soa_pkg::tag_t    final_r, final_nxt;
  logic [soa_pkg::OBJ_W-1:0]   obj_r, obj_nxt;
  logic [SW-1:0]               s_r, s_nxt;
  logic                        claim_r, claim_nxt;
  logic                        grant_r, grant_nxt;
  logic                        shr_mode_r, shr_mode_nxt;
  meta_t                       cur_r, cur_nxt;
  logic [OW-1:0]               idx_r, idx_nxt;
  logic [soa_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  fix_t                        fx_r [3];
  fix_t                        fx_nxt [3];
  logic [1:0]                  fx_i_r, fx_i_nxt;

  logic [SW-1:0]         full_head_r, full_head_nxt;
  logic [SW-1:0]         partial_head_r, partial_head_nxt;
  logic [SW-1:0]         empty_head_r, empty_head_nxt;
  logic [SLAB_SLOTS-1:0] owned_r, owned_nxt;
  logic [SW-1:0]         total_r, total_nxt;

  logic [soa_pkg::CFG_DATA_W-1:0] ops_cfg_r, ops_cfg_nxt;
  logic [soa_pkg::BUDGET_W-1:0]   budget_r, budget_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [soa_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [soa_pkg::SLAB_W-1:0]      out_slab_r, out_slab_nxt;
  logic [soa_pkg::OBJ_W-1:0]       out_obj_r, out_obj_nxt;
  logic [soa_pkg::COUNT_W-1:0]     out_cnt_r, out_cnt_nxt;

  logic           m_we;
  logic [SIW-1:0] m_waddr, m_raddr;
  meta_t          m_wdata;
  logic [MW-1:0]  m_rdata;
  meta_t          m_rd;

  logic           l_we;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [OW-1:0]  l_wdata, l_rdata;

  logic [OW-1:0] ops;
  logic [SW-1:0] free_slot;
  logic          free_found;
  logic          can_claim;
  logic          in_fire;
  logic          out_free;
  logic          pick_ok;
  logic          free_ok;
  meta_t         cur_m;
  logic          meta_pop;
  logic          meta_fresh;
  logic          free_err;
  logic          move_need;
  fix_t          fx_cur;
  logic          fx_last;
  meta_t         fx_mod;
  logic [SW-1:0] head_final;

  soa_meta_store #(
    .DEPTH   (SLAB_SLOTS),
    .AW      (SIW),
    .DW      (MW),
    .RST_VAL (META_RST)
  ) u_meta (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  soa_link_ram #(
    .DEPTH (SLAB_SLOTS * MAX_OBJECTS),
    .AW    (LAW),
    .DW    (OW)
  ) u_link (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  function automatic logic [LAW-1:0] link_addr(logic [SW-1:0] s, logic [OW-1:0] o);
    return LAW'(LAW'(s) * LAW'(MAX_OBJECTS)) + LAW'(o);
  endfunction

  assign m_rd = meta_t'(m_rdata);

  always_comb begin
    if (ops_cfg_r == '0) begin
      ops = OW'(1);
    end else if (32'(ops_cfg_r) > MAX_OBJECTS) begin
      ops = OW'(MAX_OBJECTS);
    end else begin
      ops = OW'(ops_cfg_r);
    end
  end

  always_comb begin
    free_slot  = SLAB_NIL;
    free_found = 1'b0;
    for (int i = SLAB_SLOTS - 1; i >= 0; i--) begin
      if (!owned_r[i]) begin
        free_slot  = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    case (final_r)
      soa_pkg::TAG_FULL:    head_final = full_head_r;
      soa_pkg::TAG_PARTIAL: head_final = partial_head_r;
      soa_pkg::TAG_EMPTY:   head_final = empty_head_r;
      default:              head_final = SLAB_NIL;
    endcase
  end

  assign can_claim  = free_found && (32'(total_r) < 32'(budget_r));
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign pick_ok    = (partial_head_r != SLAB_NIL) || (empty_head_r != SLAB_NIL) || can_claim;
  assign free_ok    = (32'(in_ch.slab_sel) < SLAB_SLOTS) && owned_r[SIW'(in_ch.slab_sel)];
  assign cur_m      = claim_r ? META_RST : m_rd;
  assign meta_pop   = cur_m.fhead != OBJ_NIL;
  assign meta_fresh = cur_m.fresh < ops;
  assign free_err   = (m_rd.used == '0) || (32'(obj_r) >= 32'(ops));
  assign move_need  = orig_r != final_r;
  assign fx_cur     = fx_r[fx_i_r];
  assign fx_last    = fx_i_r == 2'd2;

  always_comb begin
    fx_mod = m_rd;
    if (fx_cur.is_next) begin
      fx_mod.link_next = fx_cur.val;
    end else begin
      fx_mod.link_prev = fx_cur.val;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      soa_pkg::S_IDLE: begin
        if (in_fire) begin
          case (soa_pkg::req_t'(in_ch.req_type))
            soa_pkg::REQ_ALLOC:  state_nxt = pick_ok ? soa_pkg::S_META : soa_pkg::S_DONE;
            soa_pkg::REQ_FREE:   state_nxt = free_ok ? soa_pkg::S_META : soa_pkg::S_DONE;
            soa_pkg::REQ_SHRINK: state_nxt = soa_pkg::S_SHR_CHK;
            default:             state_nxt = soa_pkg::S_DONE;
          endcase
        end
      end
      soa_pkg::S_META: begin
        if (req_r == soa_pkg::REQ_ALLOC) begin
          state_nxt = meta_pop ? soa_pkg::S_LINK : soa_pkg::S_PLAN;
        end else begin
          state_nxt = free_err ? soa_pkg::S_DONE : soa_pkg::S_PLAN;
        end
      end
      soa_pkg::S_LINK: state_nxt = soa_pkg::S_PLAN;
      soa_pkg::S_PLAN: state_nxt = move_need ? soa_pkg::S_FX_RD : soa_pkg::S_WB;
      soa_pkg::S_FX_RD: begin
        if (fx_cur.en) begin
          state_nxt = soa_pkg::S_FX_WR;
        end else if (fx_last) begin
          state_nxt = shr_mode_r ? soa_pkg::S_SHR_CHK : soa_pkg::S_WB;
        end
      end
      soa_pkg::S_FX_WR: begin
        if (fx_last) begin
          state_nxt = shr_mode_r ? soa_pkg::S_SHR_CHK : soa_pkg::S_WB;
        end else begin
          state_nxt = soa_pkg::S_FX_RD;
        end
      end
      soa_pkg::S_WB: state_nxt = soa_pkg::S_DONE;
      soa_pkg::S_SHR_CHK: begin
        state_nxt = (empty_head_r == SLAB_NIL) ? soa_pkg::S_DONE : soa_pkg::S_SHR_RD;
      end
      soa_pkg::S_SHR_RD: state_nxt = soa_pkg::S_FX_RD;
      soa_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = soa_pkg::S_IDLE;
        end
      end
      default: state_nxt = soa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_nxt          = req_r;
    stat_nxt         = stat_r;
    orig_nxt         = orig_r;
    final_nxt        = final_r;
    obj_nxt          = obj_r;
    s_nxt            = s_r;
    claim_nxt        = claim_r;
    grant_nxt        = grant_r;
    shr_mode_nxt     = shr_mode_r;
    cur_nxt          = cur_r;
    idx_nxt          = idx_r;
    cnt_nxt          = cnt_r;
    fx_nxt           = fx_r;
    fx_i_nxt         = fx_i_r;
    full_head_nxt    = full_head_r;
    partial_head_nxt = partial_head_r;
    empty_head_nxt   = empty_head_r;
    owned_nxt        = owned_r;
    total_nxt        = total_r;
    ops_cfg_nxt      = ops_cfg_r;
    budget_nxt       = budget_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_slab_nxt     = out_slab_r;
    out_obj_nxt      = out_obj_r;
    out_cnt_nxt      = out_cnt_r;
    m_we             = 1'b0;
    m_waddr          = SIW'(s_r);
    m_wdata          = cur_r;
    m_raddr          = SIW'(s_r);
    l_we             = 1'b0;
    l_waddr          = link_addr(s_r, OW'(obj_r));
    l_wdata          = cur_m.fhead;
    l_raddr          = link_addr(s_r, cur_m.fhead);
    in_ch.ready      = state_r == soa_pkg::S_IDLE;

    if (cfg_we && cfg_index == soa_pkg::CFG_OBJ_COUNT) begin
      ops_cfg_nxt = cfg_data;
    end
    if (cfg_we && cfg_index == soa_pkg::CFG_SLAB_BUDGET) begin
      budget_nxt = soa_pkg::BUDGET_W'(cfg_data);
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      soa_pkg::S_IDLE: begin
        if (in_fire) begin
          req_nxt      = soa_pkg::req_t'(in_ch.req_type);
          obj_nxt      = in_ch.object_sel;
          stat_nxt     = soa_pkg::ST_OK;
          grant_nxt    = 1'b0;
          cnt_nxt      = '0;
          claim_nxt    = 1'b0;
          shr_mode_nxt = 1'b0;
          case (soa_pkg::req_t'(in_ch.req_type))
            soa_pkg::REQ_ALLOC: begin
              if (partial_head_r != SLAB_NIL) begin
                s_nxt = partial_head_r;
              end else if (empty_head_r != SLAB_NIL) begin
                s_nxt = empty_head_r;
              end else if (can_claim) begin
                s_nxt                  = free_slot;
                claim_nxt              = 1'b1;
                owned_nxt[SIW'(free_slot)] = 1'b1;
                total_nxt              = total_r + SW'(1);
              end else begin
                stat_nxt = soa_pkg::ST_NO_SLAB;
              end
              m_raddr = SIW'(s_nxt);
            end
            soa_pkg::REQ_FREE: begin
              s_nxt   = SW'(in_ch.slab_sel);
              m_raddr = SIW'(in_ch.slab_sel);
              if (!free_ok) begin
                stat_nxt = soa_pkg::ST_NOT_OWNED;
              end
            end
            soa_pkg::REQ_SHRINK: shr_mode_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      soa_pkg::S_META: begin
        cur_nxt   = cur_m;
        orig_nxt  = cur_m.tag;
        final_nxt = cur_m.tag;
        if (req_r == soa_pkg::REQ_ALLOC) begin
          if (meta_pop) begin
            ;
          end else if (meta_fresh) begin
            idx_nxt       = cur_m.fresh;
            cur_nxt.fresh = cur_m.fresh + OW'(1);
            cur_nxt.used  = cur_m.used + OW'(1);
            final_nxt     = ((cur_m.used + OW'(1)) >= ops) ? soa_pkg::TAG_FULL
                                                          : soa_pkg::TAG_PARTIAL;
            grant_nxt     = 1'b1;
          end else begin
            final_nxt = soa_pkg::TAG_FULL;
            stat_nxt  = soa_pkg::ST_NO_SLAB;
          end
        end else begin
          if (m_rd.used == '0) begin
            stat_nxt = soa_pkg::ST_DOUBLE_FREE;
          end else if (32'(obj_r) >= 32'(ops)) begin
            stat_nxt = soa_pkg::ST_BAD_INDEX;
          end else begin
            l_we          = 1'b1;
            cur_nxt.fhead = OW'(obj_r);
            cur_nxt.used  = m_rd.used - OW'(1);
            if (m_rd.used == OW'(1)) begin
              final_nxt = soa_pkg::TAG_EMPTY;
            end else if (m_rd.tag == soa_pkg::TAG_FULL) begin
              final_nxt = soa_pkg::TAG_PARTIAL;
            end
          end
        end
      end
      soa_pkg::S_LINK: begin
        idx_nxt       = cur_r.fhead;
        cur_nxt.fhead = l_rdata;
        cur_nxt.used  = cur_r.used + OW'(1);
        final_nxt     = ((cur_r.used + OW'(1)) >= ops) ? soa_pkg::TAG_FULL
                                                      : soa_pkg::TAG_PARTIAL;
        grant_nxt     = 1'b1;
      end
      soa_pkg::S_PLAN: begin
        if (move_need) begin
          fx_nxt[0] = '{en: (orig_r != soa_pkg::TAG_NONE) && (cur_r.link_prev != SLAB_NIL),
                        is_next: 1'b1, addr: cur_r.link_prev, val: cur_r.link_next};
          fx_nxt[1] = '{en: (orig_r != soa_pkg::TAG_NONE) && (cur_r.link_next != SLAB_NIL),
                        is_next: 1'b0, addr: cur_r.link_next, val: cur_r.link_prev};
          fx_nxt[2] = '{en: head_final != SLAB_NIL, is_next: 1'b0, addr: head_final,
                        val: s_r};
          fx_i_nxt  = 2'd0;
          if (cur_r.link_prev == SLAB_NIL) begin
            case (orig_r)
              soa_pkg::TAG_FULL:    full_head_nxt    = cur_r.link_next;
              soa_pkg::TAG_PARTIAL: partial_head_nxt = cur_r.link_next;
              soa_pkg::TAG_EMPTY:   empty_head_nxt   = cur_r.link_next;
              default: ;
            endcase
          end
          case (final_r)
            soa_pkg::TAG_FULL:    full_head_nxt    = s_r;
            soa_pkg::TAG_PARTIAL: partial_head_nxt = s_r;
            soa_pkg::TAG_EMPTY:   empty_head_nxt   = s_r;
            default: ;
          endcase
          cur_nxt.link_prev = SLAB_NIL;
          cur_nxt.link_next = head_final;
          cur_nxt.tag       = final_r;
        end
      end
      soa_pkg::S_FX_RD: begin
        m_raddr = SIW'(fx_cur.addr);
        if (!fx_cur.en && !fx_last) begin
          fx_i_nxt = fx_i_r + 2'd1;
        end
      end
      soa_pkg::S_FX_WR: begin
        m_we    = 1'b1;
        m_waddr = SIW'(fx_cur.addr);
        m_wdata = fx_mod;
        if (!fx_last) begin
          fx_i_nxt = fx_i_r + 2'd1;
        end
      end
      soa_pkg::S_WB: begin
        m_we = 1'b1;
      end
      soa_pkg::S_SHR_CHK: begin
        s_nxt   = empty_head_r;
        m_raddr = SIW'(empty_head_r);
      end
      soa_pkg::S_SHR_RD: begin
        empty_head_nxt       = m_rd.link_next;
        owned_nxt[SIW'(s_r)] = 1'b0;
        if (total_r != '0) begin
          total_nxt = total_r - SW'(1);
        end
        if (cnt_r != soa_pkg::COUNT_SAT) begin
          cnt_nxt = cnt_r + soa_pkg::COUNT_W'(1);
        end
        m_we      = 1'b1;
        m_wdata   = META_RST;
        fx_nxt[0] = '{en: m_rd.link_next != SLAB_NIL, is_next: 1'b0, addr: m_rd.link_next,
                      val: SLAB_NIL};
        fx_nxt[1] = '{en: 1'b0, is_next: 1'b0, addr: SLAB_NIL, val: SLAB_NIL};
        fx_nxt[2] = '{en: 1'b0, is_next: 1'b0, addr: SLAB_NIL, val: SLAB_NIL};
        fx_i_nxt  = 2'd0;
      end
      soa_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_slab_nxt   = grant_r ? soa_pkg::SLAB_W'(s_r) : '0;
          out_obj_nxt    = grant_r ? soa_pkg::OBJ_W'(idx_r) : '0;
          out_cnt_nxt    = cnt_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= soa_pkg::S_IDLE;
      full_head_r    <= SLAB_NIL;
      partial_head_r <= SLAB_NIL;
      empty_head_r   <= SLAB_NIL;
      owned_r        <= '0;
      total_r        <= '0;
      ops_cfg_r      <= soa_pkg::OPS_RST;
      budget_r       <= soa_pkg::BUDGET_RST;
      out_valid_r    <= 1'b0;
      fx_i_r         <= 2'd0;
      shr_mode_r     <= 1'b0;
      claim_r        <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      full_head_r    <= full_head_nxt;
      partial_head_r <= partial_head_nxt;
      empty_head_r   <= empty_head_nxt;
      owned_r        <= owned_nxt;
      total_r        <= total_nxt;
      ops_cfg_r      <= ops_cfg_nxt;
      budget_r       <= budget_nxt;
      out_valid_r    <= out_valid_nxt;
      fx_i_r         <= fx_i_nxt;
      shr_mode_r     <= shr_mode_nxt;
      claim_r        <= claim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    stat_r       <= stat_nxt;
    orig_r       <= orig_nxt;
    final_r      <= final_nxt;
    obj_r        <= obj_nxt;
    s_r          <= s_nxt;
    grant_r      <= grant_nxt;
    cur_r        <= cur_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    fx_r         <= fx_nxt;
    out_status_r <= out_status_nxt;
    out_slab_r   <= out_slab_nxt;
    out_obj_r    <= out_obj_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.granted_slab   = out_slab_r;
  assign out_ch.granted_object = out_obj_r;
  assign out_ch.released_count = out_cnt_r;

endmodule

// ===== hdl/soa_checker.sv =====
// Port-level assertions for the slab object allocator, bound to the top level.
module soa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [soa_pkg::STATUS_W-1:0]     status,
  input logic [soa_pkg::SLAB_W-1:0]       granted_slab,
  input logic [soa_pkg::OBJ_W-1:0]        granted_object,
  input logic [soa_pkg::COUNT_W-1:0]      released_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(status) && $stable(granted_slab)
                                && $stable(granted_object) && $stable(released_count))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != soa_pkg::ST_OK |->
      granted_slab == '0 && granted_object == '0 && released_count == '0)
    else $error("error result carries payload");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind slab_object_allocator_core soa_checker u_soa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .granted_slab   (out_ch.granted_slab),
  .granted_object (out_ch.granted_object),
  .released_count (out_ch.released_count)
);
